// ----- hw/rtl/smsd_pkg.sv -----
package smsd_pkg;

    // Field and accumulator widths
    localparam int SAMPLE_W = 12;
    localparam int CNT_W    = 13;
    localparam int SUM_W    = 24;
    localparam int SQS_W    = 37;
    localparam int SQ1_W    = 2 * SAMPLE_W;
    localparam int OUT_W    = 16;

    // Multiplier and derived widths
    localparam int MUL_W    = 2 * SUM_W;          // widest product: sum * sum
    localparam int PROD_W   = CNT_W + SQS_W;      // n * sum of squares
    localparam int DEN_W    = SUM_W;              // n * (n - 1) and n both fit
    localparam int DIV_W    = PROD_W + 8;         // 256 * deviation numerator
    localparam int ROOT_IN_W  = 2 * OUT_W;        // variance in Q8 fits 32 bits
    localparam int ROOT_STEPS = OUT_W;

    localparam int MAX_SAMPLES_DEF = 4096;

    // Datapath operations
    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_DIVM_LOAD = 4'd1;
    localparam logic [3:0] OP_DIV_STEP  = 4'd2;
    localparam logic [3:0] OP_DIVM_SAVE = 4'd3;
    localparam logic [3:0] OP_MUL_NLO   = 4'd4;
    localparam logic [3:0] OP_MUL_NHI   = 4'd5;
    localparam logic [3:0] OP_MUL_SS    = 4'd6;
    localparam logic [3:0] OP_MUL_NN    = 4'd7;
    localparam logic [3:0] OP_DIFF      = 4'd8;
    localparam logic [3:0] OP_ROOT_LOAD = 4'd9;
    localparam logic [3:0] OP_ROOT_STEP = 4'd10;
    localparam logic [3:0] OP_EMIT      = 4'd11;

    typedef struct packed {
        logic [3:0] op;
    } t_cmd;

    typedef struct packed {
        logic too_few;
        logic n_zero;
    } t_stat;

endpackage

// ----- hw/rtl/smsd_ctrl.sv -----
module smsd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic           i_last,
    input  smsd_pkg::t_stat i_stat,
    output smsd_pkg::t_cmd o_cmd,
    output logic           busy
);

    localparam int DIV_STEPS  = smsd_pkg::DIV_W;
    localparam int ROOT_STEPS = smsd_pkg::ROOT_STEPS;
    localparam int STEP_W = $clog2(DIV_STEPS > ROOT_STEPS ? DIV_STEPS : ROOT_STEPS);

    localparam logic [3:0] S_ACC   = 4'd0;
    localparam logic [3:0] S_FOLD  = 4'd1;
    localparam logic [3:0] S_DML   = 4'd2;
    localparam logic [3:0] S_DMS   = 4'd3;
    localparam logic [3:0] S_DMV   = 4'd4;
    localparam logic [3:0] S_M0    = 4'd5;
    localparam logic [3:0] S_M1    = 4'd6;
    localparam logic [3:0] S_M2    = 4'd7;
    localparam logic [3:0] S_M3    = 4'd8;
    localparam logic [3:0] S_DIFF  = 4'd9;
    localparam logic [3:0] S_DVS   = 4'd10;
    localparam logic [3:0] S_RL    = 4'd11;
    localparam logic [3:0] S_RS    = 4'd12;
    localparam logic [3:0] S_EMIT  = 4'd13;

    logic [3:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd.op = smsd_pkg::OP_NONE;
        unique case (r_state)
            S_ACC: begin
                if (i_accept && i_last) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: n_state = S_DML;
            S_DML: begin
                o_cmd.op = smsd_pkg::OP_DIVM_LOAD;
                n_step   = '0;
                n_state  = S_DMS;
            end
            S_DMS: begin
                o_cmd.op = smsd_pkg::OP_DIV_STEP;
                n_step   = r_step + 1'b1;
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = S_DMV;
                end
            end
            S_DMV: begin
                o_cmd.op = smsd_pkg::OP_DIVM_SAVE;
                n_state  = i_stat.too_few ? S_EMIT : S_M0;
            end
            S_M0: begin
                o_cmd.op = smsd_pkg::OP_MUL_NLO;
                n_state  = S_M1;
            end
            S_M1: begin
                o_cmd.op = smsd_pkg::OP_MUL_NHI;
                n_state  = S_M2;
            end
            S_M2: begin
                o_cmd.op = smsd_pkg::OP_MUL_SS;
                n_state  = S_M3;
            end
            S_M3: begin
                o_cmd.op = smsd_pkg::OP_MUL_NN;
                n_state  = S_DIFF;
            end
            S_DIFF: begin
                o_cmd.op = smsd_pkg::OP_DIFF;
                n_step   = '0;
                n_state  = S_DVS;
            end
            S_DVS: begin
                o_cmd.op = smsd_pkg::OP_DIV_STEP;
                n_step   = r_step + 1'b1;
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = S_RL;
                end
            end
            S_RL: begin
                o_cmd.op = smsd_pkg::OP_ROOT_LOAD;
                n_step   = '0;
                n_state  = S_RS;
            end
            S_RS: begin
                o_cmd.op = smsd_pkg::OP_ROOT_STEP;
                n_step   = r_step + 1'b1;
                if (r_step == STEP_W'(ROOT_STEPS - 1)) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.op = smsd_pkg::OP_EMIT;
                n_state  = S_ACC;
            end
            default: n_state = S_ACC;
        endcase
    end

    assign busy = (r_state != S_ACC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

// ----- hw/rtl/smsd_dp.sv -----
module smsd_dp #(
    parameter int MAX_SAMPLES = smsd_pkg::MAX_SAMPLES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  logic [smsd_pkg::SAMPLE_W-1:0]     i_sample,
    input  smsd_pkg::t_cmd                    i_cmd,
    output smsd_pkg::t_stat                   o_stat,
    output logic                              o_valid,
    output logic [smsd_pkg::OUT_W-1:0]        o_mean_q4,
    output logic [smsd_pkg::OUT_W-1:0]        o_stddev_q4,
    output logic [smsd_pkg::CNT_W-1:0]        o_sample_total,
    output logic                              o_too_few,
    output logic                              o_overflowed
);

    localparam int SAMPLE_W  = smsd_pkg::SAMPLE_W;
    localparam int CNT_W     = smsd_pkg::CNT_W;
    localparam int SUM_W     = smsd_pkg::SUM_W;
    localparam int SQS_W     = smsd_pkg::SQS_W;
    localparam int SQ1_W     = smsd_pkg::SQ1_W;
    localparam int MUL_W     = smsd_pkg::MUL_W;
    localparam int PROD_W    = smsd_pkg::PROD_W;
    localparam int DEN_W     = smsd_pkg::DEN_W;
    localparam int DIV_W     = smsd_pkg::DIV_W;
    localparam int OUT_W     = smsd_pkg::OUT_W;
    localparam int RIN_W     = smsd_pkg::ROOT_IN_W;
    localparam int RREM_W    = OUT_W + 2;
    localparam int LO_W      = SUM_W;
    localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_SAMPLES);

    // Input stage and batch accumulators
    logic                 r_pv, n_pv;
    logic [SAMPLE_W-1:0]  r_ps, n_ps;
    logic [SQ1_W-1:0]     r_psq, n_psq;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [SUM_W-1:0]     r_sum, n_sum;
    logic [SQS_W-1:0]     r_sumsq, n_sumsq;
    logic                 r_ovf, n_ovf;

    // Shared multiplier and result stages
    logic [MUL_W-1:0]     r_mul, n_mul;
    logic [PROD_W-1:0]    r_prod, n_prod;
    logic [MUL_W-1:0]     r_sqr, n_sqr;
    logic [SUM_W-1:0]     mul_a, mul_b;

    // Restoring divider: dividend shifts out, quotient shifts in
    logic [DIV_W-1:0]     r_dvd, n_dvd;
    logic [DEN_W-1:0]     r_den, n_den;
    logic [DEN_W:0]       r_rem, n_rem;
    logic [DEN_W:0]       rem_sh;
    logic                 div_ge;
    logic [PROD_W-1:0]    diff;

    // Digit-by-digit square root
    logic [RIN_W-1:0]     r_rx, n_rx;
    logic [OUT_W-1:0]     r_root, n_root;
    logic [RREM_W-1:0]    r_rrem, n_rrem;
    logic [RREM_W-1:0]    rrem_sh, rtrial;

    logic [OUT_W-1:0]     r_mean, n_mean;

    // Result registers
    logic                 r_ov, n_ov;
    logic [OUT_W-1:0]     r_om, n_om, r_osd, n_osd;
    logic [CNT_W-1:0]     r_on, n_on;
    logic                 r_otf, n_otf, r_oovf, n_oovf;

    assign o_stat.too_few = (r_count < CNT_W'(2));
    assign o_stat.n_zero  = (r_count == '0);

    always_comb begin
        unique case (i_cmd.op)
            smsd_pkg::OP_MUL_NLO: begin
                mul_a = SUM_W'(r_count);
                mul_b = r_sumsq[LO_W-1:0];
            end
            smsd_pkg::OP_MUL_NHI: begin
                mul_a = SUM_W'(r_count);
                mul_b = SUM_W'(r_sumsq[SQS_W-1:LO_W]);
            end
            smsd_pkg::OP_MUL_SS: begin
                mul_a = r_sum;
                mul_b = r_sum;
            end
            smsd_pkg::OP_MUL_NN: begin
                mul_a = SUM_W'(r_count);
                mul_b = SUM_W'(r_count - 1'b1);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign rem_sh  = {r_rem[DEN_W-1:0], r_dvd[DIV_W-1]};
    assign div_ge  = (rem_sh >= {1'b0, r_den});
    assign diff    = (r_prod > PROD_W'(r_sqr)) ? (r_prod - PROD_W'(r_sqr)) : '0;
    assign rrem_sh = {r_rrem[RREM_W-3:0], r_rx[RIN_W-1:RIN_W-2]};
    assign rtrial  = {r_root, 2'b01};

    always_comb begin
        n_pv    = i_accept;
        n_ps    = r_ps;
        n_psq   = r_psq;
        n_count = r_count;
        n_sum   = r_sum;
        n_sumsq = r_sumsq;
        n_ovf   = r_ovf;
        n_mul   = r_mul;
        n_prod  = r_prod;
        n_sqr   = r_sqr;
        n_dvd   = r_dvd;
        n_den   = r_den;
        n_rem   = r_rem;
        n_rx    = r_rx;
        n_root  = r_root;
        n_rrem  = r_rrem;
        n_mean  = r_mean;
        n_ov    = 1'b0;
        n_om    = r_om;
        n_osd   = r_osd;
        n_on    = r_on;
        n_otf   = r_otf;
        n_oovf  = r_oovf;

        // Register the sample and its square; fold it in on the next cycle
        if (i_accept) begin
            n_ps  = i_sample;
            n_psq = i_sample * i_sample;
        end
        if (r_pv) begin
            if (r_count < MAX_N) begin
                n_count = r_count + 1'b1;
                n_sum   = r_sum + SUM_W'(r_ps);
                n_sumsq = r_sumsq + SQS_W'(r_psq);
            end else begin
                n_ovf = 1'b1;
            end
        end

        unique case (i_cmd.op)
            smsd_pkg::OP_NONE: ;
            smsd_pkg::OP_DIVM_LOAD: begin
                n_dvd = DIV_W'({r_sum, 4'b0000});
                n_den = DEN_W'(r_count);
                n_rem = '0;
            end
            smsd_pkg::OP_DIV_STEP: begin
                n_rem = div_ge ? (rem_sh - {1'b0, r_den}) : rem_sh;
                n_dvd = {r_dvd[DIV_W-2:0], div_ge};
            end
            smsd_pkg::OP_DIVM_SAVE: begin
                n_mean = o_stat.n_zero ? '0 : r_dvd[OUT_W-1:0];
            end
            smsd_pkg::OP_MUL_NLO: begin
                n_mul = mul_a * mul_b;
            end
            smsd_pkg::OP_MUL_NHI: begin
                n_mul  = mul_a * mul_b;
                n_prod = PROD_W'(r_mul);
            end
            smsd_pkg::OP_MUL_SS: begin
                n_mul  = mul_a * mul_b;
                n_prod = r_prod + (PROD_W'(r_mul) << LO_W);
            end
            smsd_pkg::OP_MUL_NN: begin
                n_mul = mul_a * mul_b;
                n_sqr = r_mul;
            end
            smsd_pkg::OP_DIFF: begin
                n_den = r_mul[DEN_W-1:0];
                n_dvd = {diff, 8'h00};
                n_rem = '0;
            end
            smsd_pkg::OP_ROOT_LOAD: begin
                n_rx   = r_dvd[RIN_W-1:0];
                n_root = '0;
                n_rrem = '0;
            end
            smsd_pkg::OP_ROOT_STEP: begin
                n_rx = {r_rx[RIN_W-3:0], 2'b00};
                if (rrem_sh >= rtrial) begin
                    n_rrem = rrem_sh - rtrial;
                    n_root = {r_root[OUT_W-2:0], 1'b1};
                end else begin
                    n_rrem = rrem_sh;
                    n_root = {r_root[OUT_W-2:0], 1'b0};
                end
            end
            smsd_pkg::OP_EMIT: begin
                n_ov    = 1'b1;
                n_om    = r_mean;
                n_osd   = o_stat.too_few ? '0 : r_root;
                n_on    = r_count;
                n_otf   = o_stat.too_few;
                n_oovf  = r_ovf;
                // Clear the batch for the next one
                n_count = '0;
                n_sum   = '0;
                n_sumsq = '0;
                n_ovf   = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv    <= 1'b0;
            r_count <= '0;
            r_sum   <= '0;
            r_sumsq <= '0;
            r_ovf   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_pv    <= n_pv;
            r_count <= n_count;
            r_sum   <= n_sum;
            r_sumsq <= n_sumsq;
            r_ovf   <= n_ovf;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ps   <= n_ps;
        r_psq  <= n_psq;
        r_mul  <= n_mul;
        r_prod <= n_prod;
        r_sqr  <= n_sqr;
        r_dvd  <= n_dvd;
        r_den  <= n_den;
        r_rem  <= n_rem;
        r_rx   <= n_rx;
        r_root <= n_root;
        r_rrem <= n_rrem;
        r_mean <= n_mean;
        r_om   <= n_om;
        r_osd  <= n_osd;
        r_on   <= n_on;
        r_otf  <= n_otf;
        r_oovf <= n_oovf;
    end

    assign o_valid        = r_ov;
    assign o_mean_q4      = r_om;
    assign o_stddev_q4    = r_osd;
    assign o_sample_total = r_on;
    assign o_too_few      = r_otf;
    assign o_overflowed   = r_oovf;

endmodule

// ----- hw/rtl/sample_mean_stddev.sv -----
// Batch mean and sample standard deviation of 12-bit converter samples. Samples
// transfer one per clock while busy is low: start high with busy low accepts
// i_sample, and i_last marks the final sample of a batch. After the last sample
// busy rises while a shared multiplier, a one-bit-per-cycle restoring divider (58
// steps, run once for the mean and once for the variance) and a square root taking
// two radicand bits per step (16 steps) finish the result; batches of fewer than
// two samples skip the variance.
// The result appears for exactly one cycle with o_valid high, in the first cycle
// with busy low again; the receiver cannot stall it, so capture it on that cycle.
// Both outputs carry 4 fraction bits, truncated. Samples beyond MAX_SAMPLES in a
// batch are dropped and reported through o_overflowed.
module sample_mean_stddev #(
    parameter int MAX_SAMPLES = smsd_pkg::MAX_SAMPLES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [smsd_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                          i_last,
    output logic                          o_valid,
    output logic [smsd_pkg::OUT_W-1:0]    o_mean_q4,
    output logic [smsd_pkg::OUT_W-1:0]    o_stddev_q4,
    output logic [smsd_pkg::CNT_W-1:0]    o_sample_total,
    output logic                          o_too_few,
    output logic                          o_overflowed
);

    smsd_pkg::t_cmd  cmd;
    smsd_pkg::t_stat stat;
    logic            accept;

    // A transfer happens whenever start meets an idle block
    assign accept = start && !busy;

    // Sequence the end-of-batch arithmetic
    smsd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_last   (i_last),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    // Accumulate samples and hold the divider, root and result registers
    smsd_dp #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_sample       (i_sample),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_valid        (o_valid),
        .o_mean_q4      (o_mean_q4),
        .o_stddev_q4    (o_stddev_q4),
        .o_sample_total (o_sample_total),
        .o_too_few      (o_too_few),
        .o_overflowed   (o_overflowed)
    );

endmodule

// ----- verif/testbench.sv -----
module testbench;

    localparam int SAMPLE_W = smsd_pkg::SAMPLE_W;
    localparam int CNT_W    = smsd_pkg::CNT_W;
    localparam int SUM_W    = smsd_pkg::SUM_W;
    localparam int SQS_W    = smsd_pkg::SQS_W;
    localparam int OUT_W    = smsd_pkg::OUT_W;

    // Batch size limit of the block under test (its default parameter)
    localparam int MAX_COUNT      = smsd_pkg::MAX_SAMPLES_DEF;
    // Stop the random part after this many transfers of ordinary batches
    localparam int RANDOM_ITEMS   = 1650;
    // Cycles with neither a transfer nor a result before the run is declared hung;
    // one batch costs its busy stretch plus the result strobe and a sender gap
    localparam int WATCHDOG_LIMIT = 1000;
    // Quiet cycles after the last result, to catch a stray strobe
    localparam int DRAIN_CYCLES   = 200;

    typedef struct packed {
        logic [OUT_W-1:0] mean_q4;
        logic [OUT_W-1:0] stddev_q4;
        logic [CNT_W-1:0] sample_total;
        logic             too_few;
        logic             overflowed;
    } t_smsd_result;

    // One row of the directed table; typed rows carry a hand-written result
    typedef struct {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
        bit                  typed;
        t_smsd_result        result;
    } t_stim_row;

    // Shapes of sample content in a random batch
    typedef enum int {
        FILL_ANY,
        FILL_RAILS,
        FILL_NARROW,
        FILL_FLAT
    } t_fill;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [SAMPLE_W-1:0] i_sample;
    logic                i_last;
    logic                o_valid;
    logic [OUT_W-1:0]    o_mean_q4;
    logic [OUT_W-1:0]    o_stddev_q4;
    logic [CNT_W-1:0]    o_sample_total;
    logic                o_too_few;
    logic                o_overflowed;

    // Batch accumulators of the predictor, cleared after every result
    logic [CNT_W-1:0]    acc_count;
    logic [SUM_W-1:0]    acc_sum;
    logic [SQS_W-1:0]    acc_sqsum;
    logic                acc_dropped;

    t_smsd_result        pending_results[$];
    t_stim_row           directed_rows[$];
    int                  mismatches;
    int                  stall_cycles;
    bit                  idle_en;

    sample_mean_stddev u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_sample       (i_sample),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .o_mean_q4      (o_mean_q4),
        .o_stddev_q4    (o_stddev_q4),
        .o_sample_total (o_sample_total),
        .o_too_few      (o_too_few),
        .o_overflowed   (o_overflowed)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Floor of the square root, one result bit per pass, highest pair first
    function automatic longint unsigned floor_root(input longint unsigned x);
        longint unsigned rem;
        longint unsigned root;
        longint unsigned bit_w;
        rem   = x;
        root  = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > rem) bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (rem >= root + bit_w) begin
                rem  = rem - (root + bit_w);
                root = (root >> 1) + bit_w;
            end else begin
                root = root >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return root;
    endfunction

    // Fold one transferred sample into the batch; on the last sample form the
    // mean and deviation from the exact sums, then clear the batch
    task automatic track_sample(input logic [SAMPLE_W-1:0] s, input logic l,
                                output bit got, output t_smsd_result r);
        longint unsigned n;
        longint unsigned mean;
        longint unsigned dev;
        longint unsigned prod;
        longint unsigned sq;
        longint unsigned diff;
        got = 1'b0;
        r   = '0;
        // Drop samples once the batch is full, but remember that it happened
        if (acc_count < MAX_COUNT) begin
            acc_count = acc_count + 1'b1;
            acc_sum   = acc_sum + SUM_W'(s);
            acc_sqsum = acc_sqsum + SQS_W'(s) * SQS_W'(s);
        end else begin
            acc_dropped = 1'b1;
        end
        if (l) begin
            n    = acc_count;
            mean = (n != 0) ? (64'(acc_sum) * 16) / n : 0;
            dev  = 0;
            if (n >= 2) begin
                prod = n * 64'(acc_sqsum);
                sq   = 64'(acc_sum) * 64'(acc_sum);
                diff = (prod > sq) ? prod - sq : 0;
                dev  = floor_root((diff * 256) / (n * (n - 1)));
            end
            r.mean_q4      = mean[OUT_W-1:0];
            r.stddev_q4    = dev[OUT_W-1:0];
            r.sample_total = n[CNT_W-1:0];
            r.too_few      = (n < 2);
            r.overflowed   = acc_dropped;
            got            = 1'b1;
            acc_count      = '0;
            acc_sum        = '0;
            acc_sqsum      = '0;
            acc_dropped    = 1'b0;
        end
    endtask

    // Present one sample at a falling edge, hold it until the block takes it,
    // and return at the next falling edge with start still high
    task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic l,
                               input bit use_typed, input t_smsd_result typed);
        bit           got;
        t_smsd_result r;
        while (idle_en && $urandom_range(99) < 10) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start    <= 1'b1;
        i_sample <= s;
        i_last   <= l;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        track_sample(s, l, got, r);
        if (got) pending_results.push_back(use_typed ? typed : r);
        @(negedge i_clk);
    endtask

    task automatic add_row(input logic [SAMPLE_W-1:0] s, input logic l, input bit typed,
                           input int mean, input int dev, input int total,
                           input logic few, input logic dropped);
        t_stim_row row;
        row.sample                = s;
        row.last                  = l;
        row.typed                 = typed;
        row.result.mean_q4        = OUT_W'(mean);
        row.result.stddev_q4      = OUT_W'(dev);
        row.result.sample_total   = CNT_W'(total);
        row.result.too_few        = few;
        row.result.overflowed     = dropped;
        directed_rows.push_back(row);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample(input t_fill mode, input int base);
        int v;
        case (mode)
            FILL_RAILS: begin
                v = $urandom_range(1) ? 4095 : 0;
            end
            FILL_NARROW: begin
                v = base + int'($urandom_range(8)) - 4;
                if (v < 0) v = 0;
                if (v > 4095) v = 4095;
            end
            FILL_FLAT: begin
                v = base;
            end
            default: begin
                v = $urandom_range(4095);
            end
        endcase
        return SAMPLE_W'(v);
    endfunction

    task automatic check_field(input string what, input logic [OUT_W-1:0] want,
                               input logic [OUT_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    // Compare every strobed result with the oldest expectation
    always @(posedge i_clk) begin
        t_smsd_result want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with none expected: expected nothing, %s %0d %0d %0d",
                         $time, "actual mean, stddev, total", o_mean_q4, o_stddev_q4,
                         o_sample_total);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("mean_q4", want.mean_q4, o_mean_q4);
                check_field("stddev_q4", want.stddev_q4, o_stddev_q4);
                check_field("sample_total", OUT_W'(want.sample_total), OUT_W'(o_sample_total));
                check_field("too_few", OUT_W'(want.too_few), OUT_W'(o_too_few));
                check_field("overflowed", OUT_W'(want.overflowed), OUT_W'(o_overflowed));
            end
        end
    end

    // Count cycles with neither a sample transfer nor a result; end a hung run
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin
        int    sent;
        int    len;
        int    base;
        int    pick;
        t_fill mode;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_sample     = '0;
        i_last       = 1'b0;
        mismatches   = 0;
        stall_cycles = 0;
        idle_en      = 1'b1;
        acc_count    = '0;
        acc_sum      = '0;
        acc_sqsum    = '0;
        acc_dropped  = 1'b0;

        // Directed table: single-sample batches at both rails and at mid-scale, flat
        // pairs, a full-swing pair and a batch walking distinct bit patterns
        add_row(12'h000, 1'b1, 1, 0,     0, 1, 1'b1, 1'b0);
        add_row(12'hFFF, 1'b1, 1, 65520, 0, 1, 1'b1, 1'b0);
        add_row(12'hFFF, 1'b0, 0, 0,     0, 0, 1'b0, 1'b0);
        add_row(12'hFFF, 1'b1, 1, 65520, 0, 2, 1'b0, 1'b0);
        add_row(12'h000, 1'b0, 0, 0,     0, 0, 1'b0, 1'b0);
        add_row(12'h000, 1'b1, 1, 0,     0, 2, 1'b0, 1'b0);
        add_row(12'h123, 1'b0, 0, 0,     0, 0, 1'b0, 1'b0);
        add_row(12'h123, 1'b1, 1, 4656,  0, 2, 1'b0, 1'b0);
        add_row(12'h000, 1'b0, 0, 0,     0, 0, 1'b0, 1'b0);
        add_row(12'hFFF, 1'b1, 0, 0,     0, 0, 1'b0, 1'b0);
        add_row(12'hAAA, 1'b0, 0, 0,     0, 0, 1'b0, 1'b0);
        add_row(12'h555, 1'b0, 0, 0,     0, 0, 1'b0, 1'b0);
        add_row(12'h001, 1'b0, 0, 0,     0, 0, 1'b0, 1'b0);
        add_row(12'h800, 1'b0, 0, 0,     0, 0, 1'b0, 1'b0);
        add_row(12'hFFF, 1'b1, 0, 0,     0, 0, 1'b0, 1'b0);
        add_row(12'h7FF, 1'b1, 1, 32752, 0, 1, 1'b1, 1'b0);

        // Hold reset, then release it at a falling edge
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i]) begin
            send_sample(directed_rows[i].sample, directed_rows[i].last,
                        directed_rows[i].typed, directed_rows[i].result);
        end

        // Random batches: mostly short, some single and two-sample batches,
        // a few long ones; keep one stretch free of sender gaps
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 12) len = 1;
            else if (pick < 24) len = 2;
            else if (pick < 94) len = $urandom_range(40, 3);
            else len = $urandom_range(400, 100);
            mode    = t_fill'($urandom_range(3));
            base    = $urandom_range(4095);
            idle_en = !(sent >= 700 && sent < 1000);
            for (int k = 1; k <= len; k++) begin
                send_sample(pick_sample(mode, base), k == len, 0, '0);
                sent++;
            end
        end
        start  <= 1'b0;
        i_last <= 1'b0;

        // Drain outstanding results, then watch for stray strobes
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
